[src/gpr_pkg.sv]
package gpr_pkg;

  // Longest reply the block sends (the origin packet).
  localparam int unsigned ReplyMax = 10;
  localparam int unsigned LenW     = $clog2(ReplyMax + 1);

  // Report lengths.
  localparam logic [LenW-1:0] LenSingle = LenW'(1);
  localparam logic [LenW-1:0] LenReport = LenW'(8);
  localparam logic [LenW-1:0] LenOrigin = LenW'(ReplyMax);

  // Probe byte codes.
  localparam logic [7:0] ProbeIdentLo = 8'h00;
  localparam logic [7:0] ProbeIdentHi = 8'hFF;
  localparam logic [7:0] ProbeOriginA = 8'h41;
  localparam logic [7:0] ProbeOriginB = 8'h42;
  localparam logic [7:0] ProbePoll    = 8'h40;

  // Configuration register indexes.
  localparam logic [7:0] CfgIdentByte   = 8'd0;
  localparam logic [7:0] CfgShieldLevel = 8'd1;

  // Fixed origin packet, element 0 is sent first.
  localparam logic [ReplyMax-1:0][7:0] OriginPkt = {
    8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'h1F
  };

  // One complete reply handed to the serialiser; bytes[0] goes out first.
  typedef struct packed {
    logic [LenW-1:0]           len;
    logic [ReplyMax-1:0][7:0]  bytes;
  } reply_t;

  // Persistent stick state carried between polls.
  typedef struct packed {
    logic [7:0] dir_active;
    logic [7:0] dir_locked;
    logic [7:0] cstick_x;
    logic [7:0] cstick_y;
    logic [1:0] trig;
  } socd_state_t;

endpackage

[src/gpr_socd.sv]
module gpr_socd (
  input  gpr_pkg::socd_state_t state_i,
  input  logic [4:0]           face_i,
  input  logic [3:0]           shoulder_i,
  input  logic [3:0]           stick_i,
  input  logic [3:0]           cstick_i,
  input  logic [1:0]           mods_i,
  input  logic [7:0]           shield_level_i,
  output gpr_pkg::socd_state_t state_o,
  output gpr_pkg::reply_t      report_o
);
  import gpr_pkg::*;

  typedef enum logic [3:0] {
    DirRightDown, DirRightUp, DirRight, DirLeftDown, DirLeftUp,
    DirLeft, DirDown, DirUp, DirCenter
  } dir_e;

  typedef enum logic [1:0] {
    MselDefault, MselX, MselY
  } msel_e;

  logic [7:0] held;
  logic [7:0] act;
  logic [7:0] lock;
  logic       mx, my;
  msel_e      msel;
  dir_e       dir;
  logic [15:0] stick_xy;
  logic [7:0] cx, cy;
  logic [1:0] trig;
  logic [7:0] side;
  logic [7:0] ltr;
  logic [3:0] res_mu, res_ml, res_cu, res_cl;

  // Last-input-priority for one opposite pair; returns {aa, ab, la, lb}.
  function automatic logic [3:0] resolve_pair(input logic ha, input logic hb,
                                               input logic aa_in, input logic ab_in,
                                               input logic la_in, input logic lb_in);
    logic aa, ab, la, lb;
    aa = aa_in & ha;
    la = la_in & ha;
    ab = ab_in & hb;
    lb = lb_in & hb;
    if (ha && !la) begin
      if (!hb || lb) begin
        aa = 1'b1;
      end else if (aa) begin
        aa = 1'b0;
        la = 1'b1;
      end
    end
    if (hb && !lb) begin
      if (!ha || la) begin
        ab = 1'b1;
      end else if (ab) begin
        ab = 1'b0;
        lb = 1'b1;
      end
    end
    return {aa, ab, la, lb};
  endfunction

  // Coordinate table, returns {x, y}.
  function automatic logic [15:0] stick_lookup(input dir_e d, input msel_e m);
    logic [15:0] xy;
    xy = {8'd127, 8'd127};
    case (d)
      DirRightDown: begin
        case (m)
          MselX:   xy = {8'd222, 8'd88};
          MselY:   xy = {8'd168, 8'd34};
          default: xy = {8'd217, 8'd39};
        endcase
      end
      DirRightUp: begin
        case (m)
          MselX:   xy = {8'd222, 8'd168};
          MselY:   xy = {8'd168, 8'd222};
          default: xy = {8'd217, 8'd217};
        endcase
      end
      DirRight: begin
        case (m)
          MselX:   xy = {8'd212, 8'd127};
          MselY:   xy = {8'd171, 8'd127};
          default: xy = {8'd255, 8'd127};
        endcase
      end
      DirLeftDown: begin
        case (m)
          MselX:   xy = {8'd34, 8'd88};
          MselY:   xy = {8'd88, 8'd34};
          default: xy = {8'd39, 8'd39};
        endcase
      end
      DirLeftUp: begin
        case (m)
          MselX:   xy = {8'd34, 8'd168};
          MselY:   xy = {8'd88, 8'd222};
          default: xy = {8'd39, 8'd217};
        endcase
      end
      DirLeft: begin
        case (m)
          MselX:   xy = {8'd44, 8'd127};
          MselY:   xy = {8'd85, 8'd127};
          default: xy = {8'd0, 8'd127};
        endcase
      end
      DirDown: begin
        case (m)
          MselX:   xy = {8'd127, 8'd60};
          MselY:   xy = {8'd127, 8'd34};
          default: xy = {8'd127, 8'd0};
        endcase
      end
      DirUp: begin
        case (m)
          MselX:   xy = {8'd127, 8'd196};
          MselY:   xy = {8'd127, 8'd222};
          default: xy = {8'd127, 8'd255};
        endcase
      end
      default: xy = {8'd127, 8'd127};
    endcase
    return xy;
  endfunction

  assign held = {cstick_i, stick_i};
  assign mx   = mods_i[1];
  assign my   = mods_i[0];

  // Direction resolution: up/down first, then left/right, main stick then c-stick.
  assign res_mu = resolve_pair(held[3], held[2], state_i.dir_active[3],
                               state_i.dir_active[2], state_i.dir_locked[3],
                               state_i.dir_locked[2]);
  assign res_ml = resolve_pair(held[1], held[0], state_i.dir_active[1],
                               state_i.dir_active[0], state_i.dir_locked[1],
                               state_i.dir_locked[0]);
  assign res_cu = resolve_pair(held[7], held[6], state_i.dir_active[7],
                               state_i.dir_active[6], state_i.dir_locked[7],
                               state_i.dir_locked[6]);
  assign res_cl = resolve_pair(held[5], held[4], state_i.dir_active[5],
                               state_i.dir_active[4], state_i.dir_locked[5],
                               state_i.dir_locked[4]);

  assign act  = {res_cu[3:2], res_cl[3:2], res_mu[3:2], res_ml[3:2]};
  assign lock = {res_cu[1:0], res_cl[1:0], res_mu[1:0], res_ml[1:0]};

  // Main stick direction and modifier choice.
  always_comb begin
    if (mx && !my) begin
      msel = MselX;
    end else if (my && !mx) begin
      msel = MselY;
    end else begin
      msel = MselDefault;
    end
    if (act[0]) begin
      dir = act[2] ? DirRightDown : (act[3] ? DirRightUp : DirRight);
    end else if (act[1]) begin
      dir = act[2] ? DirLeftDown : (act[3] ? DirLeftUp : DirLeft);
    end else if (act[2]) begin
      dir = DirDown;
    end else if (act[3]) begin
      dir = DirUp;
    end else begin
      dir = DirCenter;
    end
  end

  assign stick_xy = stick_lookup(dir, msel);

  // C-stick position or d-pad, triggers and side byte.
  always_comb begin
    side = 8'h80;
    cx   = state_i.cstick_x;
    cy   = state_i.cstick_y;
    if (mx && my) begin
      side[0] = act[5];
      side[1] = act[4];
      side[2] = act[6];
      side[3] = act[7];
    end else if (act[4]) begin
      if (!act[6] && !act[7]) begin
        cx = 8'd255;
        cy = 8'd127;
      end
    end else if (act[5]) begin
      if (!act[6] && !act[7]) begin
        cx = 8'd0;
        cy = 8'd127;
      end
    end else if (act[7]) begin
      cx = 8'd127;
      cy = 8'd255;
    end else if (act[6]) begin
      cx = 8'd127;
      cy = 8'd0;
    end else begin
      cx = 8'd127;
      cy = 8'd127;
    end
    side[4] = shoulder_i[0];
    if (shoulder_i[3]) begin
      ltr  = shield_level_i;
      trig = state_i.trig;
    end else begin
      ltr  = 8'd0;
      trig = shoulder_i[2:1];
    end
    side[6:5] = trig;
  end

  assign state_o.dir_active = act;
  assign state_o.dir_locked = lock;
  assign state_o.cstick_x   = cx;
  assign state_o.cstick_y   = cy;
  assign state_o.trig       = trig;

  // Report layout in send order; the unused tail bytes stay zero.
  always_comb begin
    report_o.len      = LenReport;
    report_o.bytes    = '0;
    report_o.bytes[0] = {3'b000, face_i};
    report_o.bytes[1] = side;
    report_o.bytes[2] = stick_xy[15:8];
    report_o.bytes[3] = stick_xy[7:0];
    report_o.bytes[4] = cx;
    report_o.bytes[5] = cy;
    report_o.bytes[6] = ltr;
    report_o.bytes[7] = 8'h00;
  end

endmodule

[src/gpr_reply_ser.sv]
module gpr_reply_ser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            reply_valid_i,
  input  gpr_pkg::reply_t reply_i,
  output logic            reply_ready_o,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,   // [7:0] tx_byte
  output logic            m_tlast    // last_byte
);
  import gpr_pkg::*;

  logic [LenW-1:0]          cnt_q, cnt_d;
  logic [ReplyMax-1:0][7:0] byte_q, byte_d;
  logic                     xfer;
  logic                     load;

  assign xfer          = m_tvalid && m_tready;
  assign reply_ready_o = (cnt_q == '0) || ((cnt_q == LenW'(1)) && m_tready);
  assign load          = reply_valid_i && reply_ready_o;

  assign m_tvalid = (cnt_q != '0);
  assign m_tlast  = (cnt_q == LenW'(1));
  assign m_tdata  = byte_q[0];

  // Load a whole reply, or shift one byte out per transfer.
  always_comb begin
    cnt_d  = cnt_q;
    byte_d = byte_q;
    if (load) begin
      cnt_d  = reply_i.len;
      byte_d = reply_i.bytes;
    end else if (xfer) begin
      cnt_d = cnt_q - LenW'(1);
      for (int i = 0; i < int'(ReplyMax) - 1; i++) begin
        byte_d[i] = byte_q[i+1];
      end
      byte_d[ReplyMax-1] = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LenW'(ReplyMax))
    else $error("reply count beyond the longest reply");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && m_tlast && !reply_valid_i) |=> !m_tvalid)
    else $error("byte left over after the final transfer");

  a_mid_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !m_tlast) |=> (m_tvalid && cnt_q == $past(cnt_q) - LenW'(1)))
    else $error("reply cut short");

endmodule

[src/gamepad_poll_responder_socd_core.sv]
// Gamepad poll responder with last-input-priority SOCD resolution.
//
// Input stream (s_*): one transfer per received probe byte, together with
// the current button levels. Output stream (m_*): the reply bytes, one per
// transfer, with m_tlast on the final byte of each reply. Replies are one
// byte (identify or echo), ten bytes (origin) or eight bytes (poll report);
// a poll byte and the next byte produce nothing, the byte after that
// produces the report. Configuration writes (cfg_*) are always accepted.
//
// A probe is registered on accept in the input register and loaded into the
// output serialiser once that is ready; the serialiser register drives the
// reply bytes. The serialiser sends one byte per cycle while the receiver
// accepts them; swallowed bytes leave the input register without waiting
// for the serialiser. The input register accepts the next item while the
// last byte of a reply is being sent.
//
// Reset clears the poll phase, direction and lock bits, centres the
// c-stick, clears the trigger bits and loads identity byte 9, shield_level 17.
// When the receiver stalls, the current byte is held and once the input
// register is full s_tready falls until the pending reply can be loaded.
module gamepad_poll_responder_socd_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] rx_byte, [12:8] face_buttons, [16:13] shoulder_buttons,
  // [20:17] stick_held, [24:21] cstick_held, [26:25] modifiers, rest zero
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] tx_byte
  output logic        m_tlast,   // last_byte
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import gpr_pkg::*;

  typedef enum logic [2:0] {
    PhIdle  = 3'b001,
    PhSkip1 = 3'b010,
    PhSkip2 = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        in_vld_q, in_vld_d;
  logic [26:0] in_q;
  logic [7:0]  ident_byte_q, shield_level_q;
  socd_state_t st_q, st_next;
  reply_t      report;
  reply_t      reply;
  logic        has_reply;
  logic        ser_ready;
  logic        consume;
  logic        in_xfer;
  logic [7:0]  rx;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_byte_q   <= 8'd9;
      shield_level_q <= 8'd17;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdentByte) begin
        ident_byte_q <= cfg_data_i;
      end else if (cfg_index_i == CfgShieldLevel) begin
        shield_level_q <= cfg_data_i;
      end
    end
  end

  // Input register.
  assign in_xfer  = s_tvalid && s_tready;
  assign s_tready = !in_vld_q || consume;
  assign in_vld_d = in_xfer ? 1'b1 : (consume ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= s_tdata[26:0];
    end
  end

  assign rx = in_q[7:0];

  gpr_socd u_socd (
    .state_i        (st_q),
    .face_i         (in_q[12:8]),
    .shoulder_i     (in_q[16:13]),
    .stick_i        (in_q[20:17]),
    .cstick_i       (in_q[24:21]),
    .mods_i         (in_q[26:25]),
    .shield_level_i (shield_level_q),
    .state_o        (st_next),
    .report_o       (report)
  );

  // Probe decode and reply selection.
  always_comb begin
    phase_d     = phase_q;
    has_reply   = 1'b0;
    reply.len   = LenSingle;
    reply.bytes = '0;
    case (phase_q)
      PhIdle: begin
        if (rx == ProbeIdentLo || rx == ProbeIdentHi) begin
          has_reply      = 1'b1;
          reply.bytes[0] = ident_byte_q;
        end else if (rx == ProbeOriginA || rx == ProbeOriginB) begin
          has_reply   = 1'b1;
          reply.len   = LenOrigin;
          reply.bytes = OriginPkt;
        end else if (rx == ProbePoll) begin
          phase_d = PhSkip1;
        end else begin
          has_reply      = 1'b1;
          reply.bytes[0] = rx;
        end
      end
      PhSkip1: begin
        phase_d = PhSkip2;
      end
      default: begin
        has_reply = 1'b1;
        reply     = report;
        phase_d   = PhIdle;
      end
    endcase
  end

  assign consume = in_vld_q && (!has_reply || ser_ready);

  // Poll phase advances when an item leaves the input register; stick state only when that item completes a report.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      st_q.dir_active <= '0;
      st_q.dir_locked <= '0;
      st_q.cstick_x   <= 8'd127;
      st_q.cstick_y   <= 8'd127;
      st_q.trig       <= '0;
    end else if (consume) begin
      phase_q <= phase_d;
      if (phase_q != PhIdle && phase_q != PhSkip1) begin
        st_q <= st_next;
      end
    end
  end

  gpr_reply_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .reply_valid_i (in_vld_q && has_reply),
    .reply_i       (reply),
    .reply_ready_o (ser_ready),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast)
  );

  a_active_not_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.dir_active & st_q.dir_locked) == 8'h00)
    else $error("direction both active and locked");

  a_skip_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && phase_q == PhSkip1) |=> (phase_q == PhSkip2))
    else $error("first swallowed byte did not advance the poll phase");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready |-> (in_vld_q && has_reply && !ser_ready))
    else $error("input stalled without a pending reply");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import gpr_pkg::*;

  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned TxnsPerPhase = 25;
  localparam int unsigned NumPhases    = 4;

  // An index past the register list; the block must ignore writes to it.
  localparam logic [7:0] CfgUnused = 8'hFF;

  // Direction bits within a held nibble; the c-stick lives in the upper nibble.
  localparam int unsigned BitRight  = 0;
  localparam int unsigned BitLeft   = 1;
  localparam int unsigned BitDown   = 2;
  localparam int unsigned BitUp     = 3;
  localparam int unsigned CstickOfs = 4;

  localparam logic [7:0] OriginBytes [10] = '{
    8'h1F, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [1:0] {PhaseIdle, PhaseFirst, PhaseSecond} poll_phase_e;
  typedef enum int unsigned {
    DirRightDown, DirRightUp, DirRight, DirLeftDown, DirLeftUp, DirLeft,
    DirDown, DirUp, DirCentre
  } stick_dir_e;
  typedef enum int unsigned {ModNone, ModX, ModY} mod_sel_e;
  typedef enum int unsigned {SinkAlways, SinkRandom, SinkSparse, SinkPattern} sink_mode_e;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } reply_beat_t;

  // Predicts the reply bytes of every accepted probe and checks each output
  // transfer against the oldest outstanding byte.
  class reply_scoreboard;
    reply_beat_t reply_q[$];
    int unsigned errors;
    int unsigned beats_checked;
    int unsigned reports_predicted;

    logic [7:0]  ident_byte;
    logic [7:0]  shield_level;
    poll_phase_e phase;
    logic [7:0]  dir_active;
    logic [7:0]  dir_locked;
    logic [7:0]  cstick_x;
    logic [7:0]  cstick_y;
    logic [1:0]  trig;

    function new();
      ident_byte   = 8'd9;
      shield_level = 8'd17;
      phase        = PhaseIdle;
      dir_active   = 8'h00;
      dir_locked   = 8'h00;
      cstick_x     = 8'd127;
      cstick_y     = 8'd127;
      trig         = 2'b00;
    endfunction

    function int unsigned pending();
      return reply_q.size();
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] val);
      if (idx == CfgIdentByte) ident_byte = val;
      else if (idx == CfgShieldLevel) shield_level = val;
    endfunction

    function void push_beat(logic [7:0] b, logic last);
      reply_beat_t beat;
      beat.tx_byte   = b;
      beat.last_byte = last;
      reply_q.push_back(beat);
    endfunction

    // Stick coordinates, x in the upper byte.
    function logic [15:0] stick_xy(stick_dir_e dir, mod_sel_e sel);
      logic [15:0] row [3];
      case (dir)
        DirRightDown: row = '{{8'd217, 8'd39}, {8'd222, 8'd88}, {8'd168, 8'd34}};
        DirRightUp:   row = '{{8'd217, 8'd217}, {8'd222, 8'd168}, {8'd168, 8'd222}};
        DirRight:     row = '{{8'd255, 8'd127}, {8'd212, 8'd127}, {8'd171, 8'd127}};
        DirLeftDown:  row = '{{8'd39, 8'd39}, {8'd34, 8'd88}, {8'd88, 8'd34}};
        DirLeftUp:    row = '{{8'd39, 8'd217}, {8'd34, 8'd168}, {8'd88, 8'd222}};
        DirLeft:      row = '{{8'd0, 8'd127}, {8'd44, 8'd127}, {8'd85, 8'd127}};
        DirDown:      row = '{{8'd127, 8'd0}, {8'd127, 8'd60}, {8'd127, 8'd34}};
        DirUp:        row = '{{8'd127, 8'd255}, {8'd127, 8'd196}, {8'd127, 8'd222}};
        default:      row = '{{8'd127, 8'd127}, {8'd127, 8'd127}, {8'd127, 8'd127}};
      endcase
      return row[int'(sel)];
    endfunction

    // Last-input priority for one opposite pair; ia is settled before ib.
    function void resolve_pair(logic [7:0] held, int unsigned ia, int unsigned ib);
      logic ha, hb, aa, ab, la, lb;
      ha = held[ia];
      hb = held[ib];
      aa = dir_active[ia];
      ab = dir_active[ib];
      la = dir_locked[ia];
      lb = dir_locked[ib];
      if (!ha) begin
        aa = 1'b0;
        la = 1'b0;
      end
      if (!hb) begin
        ab = 1'b0;
        lb = 1'b0;
      end
      if (ha && !la) begin
        if (!hb || lb) aa = 1'b1;
        else if (aa) begin
          aa = 1'b0;
          la = 1'b1;
        end
      end
      if (hb && !lb) begin
        if (!ha || la) ab = 1'b1;
        else if (ab) begin
          ab = 1'b0;
          lb = 1'b1;
        end
      end
      dir_active[ia] = aa;
      dir_active[ib] = ab;
      dir_locked[ia] = la;
      dir_locked[ib] = lb;
    endfunction

    // Builds the eight-byte report from the buttons of the completing byte.
    function void run_report(logic [31:0] item);
      logic [4:0]  face;
      logic [3:0]  shoulder, sh, ch;
      logic [1:0]  mods;
      mod_sel_e    sel;
      stick_dir_e  dir;
      logic [7:0]  side, ltr;
      logic        r, l, d, u;
      logic [15:0] xy;
      face     = item[12:8];
      shoulder = item[16:13];
      sh       = item[20:17];
      ch       = item[24:21];
      mods     = item[26:25];
      if (mods[1] && !mods[0]) sel = ModX;
      else if (mods[0] && !mods[1]) sel = ModY;
      else sel = ModNone;

      resolve_pair({4'b0000, sh}, BitUp, BitDown);
      resolve_pair({4'b0000, sh}, BitLeft, BitRight);
      resolve_pair({ch, 4'b0000}, CstickOfs + BitUp, CstickOfs + BitDown);
      resolve_pair({ch, 4'b0000}, CstickOfs + BitLeft, CstickOfs + BitRight);

      // Main stick: right, left, down, up, centre; diagonals follow down then up.
      r = dir_active[BitRight];
      l = dir_active[BitLeft];
      d = dir_active[BitDown];
      u = dir_active[BitUp];
      if (r) dir = d ? DirRightDown : (u ? DirRightUp : DirRight);
      else if (l) dir = d ? DirLeftDown : (u ? DirLeftUp : DirLeft);
      else if (d) dir = DirDown;
      else if (u) dir = DirUp;
      else dir = DirCentre;
      xy = stick_xy(dir, sel);

      // C-stick becomes the d-pad with both modifiers; a diagonal keeps its position.
      side = 8'h80;
      r = dir_active[CstickOfs + BitRight];
      l = dir_active[CstickOfs + BitLeft];
      d = dir_active[CstickOfs + BitDown];
      u = dir_active[CstickOfs + BitUp];
      if (mods == 2'b11) begin
        side[0] = l;
        side[1] = r;
        side[2] = d;
        side[3] = u;
      end else if (r) begin
        if (!d && !u) begin
          cstick_x = 8'd255;
          cstick_y = 8'd127;
        end
      end else if (l) begin
        if (!d && !u) begin
          cstick_x = 8'd0;
          cstick_y = 8'd127;
        end
      end else if (u) begin
        cstick_x = 8'd127;
        cstick_y = 8'd255;
      end else if (d) begin
        cstick_x = 8'd127;
        cstick_y = 8'd0;
      end else begin
        cstick_x = 8'd127;
        cstick_y = 8'd127;
      end

      // The light shield freezes the digital trigger bits.
      side[4] = shoulder[0];
      if (shoulder[3]) ltr = shield_level;
      else begin
        ltr  = 8'h00;
        trig = shoulder[2:1];
      end
      side[6:5] = trig;

      push_beat({3'b000, face}, 1'b0);
      push_beat(side, 1'b0);
      push_beat(xy[15:8], 1'b0);
      push_beat(xy[7:0], 1'b0);
      push_beat(cstick_x, 1'b0);
      push_beat(cstick_y, 1'b0);
      push_beat(ltr, 1'b0);
      push_beat(8'h00, 1'b1);
      reports_predicted++;
    endfunction

    function void predict_reply(logic [31:0] item);
      logic [7:0] rx;
      rx = item[7:0];
      if (phase == PhaseFirst) phase = PhaseSecond;
      else if (phase != PhaseIdle) begin
        phase = PhaseIdle;
        run_report(item);
      end else if (rx == ProbeIdentLo || rx == ProbeIdentHi) push_beat(ident_byte, 1'b1);
      else if (rx == ProbeOriginA || rx == ProbeOriginB) begin
        for (int i = 0; i < 10; i++) push_beat(OriginBytes[i], i == 9);
      end else if (rx == ProbePoll) phase = PhaseFirst;
      else push_beat(rx, 1'b1);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    task check_beat(logic [7:0] data, logic last);
      reply_beat_t want;
      beats_checked++;
      if (reply_q.size() == 0) begin
        report_mismatch($sformatf("unexpected reply byte %02h, last %0b", data, last));
        return;
      end
      want = reply_q.pop_front();
      if (data !== want.tx_byte)
        report_mismatch($sformatf("tx_byte got %02h, want %02h", data, want.tx_byte));
      if (last !== want.last_byte)
        report_mismatch($sformatf("last_byte got %0b, want %0b on byte %02h",
                                  last, want.last_byte, want.tx_byte));
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        s_tvalid    = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata     = '0;
  logic        m_tvalid;
  logic        m_tready    = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i  = '0;

  reply_scoreboard sb;
  sink_mode_e      sink_mode   = SinkRandom;
  bit              hold_req    = 1'b0;
  bit              steady      = 1'b0;
  int unsigned     burst_left  = 0;
  int unsigned     items_sent  = 0;
  int unsigned     holds_done  = 0;
  int unsigned     settings_used = 0;
  int unsigned     idle_cycles = 0;
  logic [3:0]      held_stick  = 4'h0;
  logic [3:0]      held_cstick = 4'h0;

  gamepad_poll_responder_socd_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Output monitor: every reply transfer is checked against the prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("[%0t] Watchdog: no transfer for %0d cycles", $time, IdleLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: stalls on the selected pattern, or holds off entirely on request.
  initial begin : sink_proc
    int unsigned beat_no;
    beat_no = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        beat_no++;
        case (sink_mode)
          SinkAlways:  m_tready <= 1'b1;
          SinkRandom:  m_tready <= 1'($urandom_range(0, 1));
          SinkSparse:  m_tready <= ($urandom_range(0, 3) == 0);
          default:     m_tready <= ((beat_no % 5) < 3);
        endcase
      end
    end
  end

  function automatic logic [31:0] pack_item(logic [7:0] rx, logic [4:0] face,
                                            logic [3:0] shoulder, logic [3:0] sh,
                                            logic [3:0] ch, logic [1:0] mods);
    return {5'b00000, mods, ch, sh, shoulder, face, rx};
  endfunction

  // Offers one probe until its transfer, then paces the sender in bursts.
  task automatic send_item(input logic [31:0] item);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.predict_reply(item);
    items_sent++;
    if (!steady) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // A poll with two swallowed bytes; earlier bytes carry inverted buttons so
  // that sampling on the completing byte is visible.
  task automatic send_poll(input logic [4:0] face, input logic [3:0] shoulder,
                           input logic [3:0] sh, input logic [3:0] ch,
                           input logic [1:0] mods, input logic [7:0] first,
                           input logic [7:0] second);
    send_item(pack_item(ProbePoll, ~face, ~shoulder, ~sh, ~ch, ~mods));
    send_item(pack_item(first, ~face, ~shoulder, ~sh, ~ch, ~mods));
    send_item(pack_item(second, face, shoulder, sh, ch, mods));
  endtask

  // Sender pause: every predicted byte has arrived and the block has settled.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic program_regs(input logic [7:0] ident, input logic [7:0] shield,
                              input bit poke_unused);
    write_reg(CfgIdentByte, ident);
    write_reg(CfgShieldLevel, shield);
    if (poke_unused) write_reg(CfgUnused, 8'($urandom_range(0, 255)));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Half polls, half single probes; held directions mostly evolve one bit at a
  // time, so that the priority and lock logic sees real press sequences.
  task automatic send_random_txn();
    int unsigned pick;
    int unsigned flip;
    logic [7:0]  rx;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      flip = $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) held_stick = 4'($urandom_range(0, 15));
      else held_stick[flip] = ~held_stick[flip];
      flip = $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) held_cstick = 4'($urandom_range(0, 15));
      else held_cstick[flip] = ~held_cstick[flip];
      send_poll(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)), held_stick,
                held_cstick, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end else begin
      if (pick < 62) rx = $urandom_range(0, 1) ? ProbeIdentHi : ProbeIdentLo;
      else if (pick < 70) rx = $urandom_range(0, 1) ? ProbeOriginB : ProbeOriginA;
      else rx = 8'($urandom_range(0, 255));
      send_item(pack_item(rx, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          2'($urandom_range(0, 3))));
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, on the register values left by reset.
    send_item(pack_item(ProbeIdentLo, 5'h00, 4'h0, 4'h0, 4'h0, 2'b00));
    send_item(pack_item(ProbeIdentHi, 5'h1F, 4'hF, 4'hF, 4'hF, 2'b11));
    send_item(pack_item(ProbeOriginA, 5'h00, 4'h0, 4'h0, 4'h0, 2'b00));
    send_item(pack_item(ProbeOriginB, 5'h1F, 4'hF, 4'hF, 4'hF, 2'b11));
    send_item(pack_item(8'h01, 5'h15, 4'h5, 4'h5, 4'h5, 2'b01));
    send_item(pack_item(8'hFE, 5'h0A, 4'hA, 4'hA, 4'hA, 2'b10));
    send_item(pack_item(8'h3F, 5'h00, 4'h0, 4'h0, 4'h0, 2'b00));
    send_item(pack_item(8'h43, 5'h00, 4'h0, 4'h0, 4'h0, 2'b00));
    // Centre with nothing held; the swallowed bytes look like identify probes.
    send_poll(5'h00, 4'h0, 4'h0, 4'h0, 2'b00, ProbeIdentLo, ProbeIdentHi);
    // Right alone, c-stick up, both digital triggers.
    send_poll(5'h1F, 4'b0110, 4'b0001, 4'b1000, 2'b00, ProbeOriginA, ProbeOriginB);
    // Left added over right, c-stick diagonal, light shield with z, x modifier.
    send_poll(5'h11, 4'b1001, 4'b0011, 4'b1001, 2'b10, ProbePoll, ProbePoll);
    // Right released while locked; all c-stick held with both modifiers.
    send_poll(5'h00, 4'b0000, 4'b0010, 4'b1111, 2'b11, 8'h55, 8'hAA);
    // Every main direction held, y modifier, c-stick released.
    send_poll(5'h0E, 4'b0100, 4'b1111, 4'b0000, 2'b01, 8'h00, 8'hFF);

    // Random phases, each under its own register setting and receiver pattern.
    for (int phase_no = 0; phase_no < NumPhases; phase_no++) begin
      wait_drained();
      case (phase_no)
        0: program_regs(8'h00, 8'h00, 1'b0);
        1: program_regs(8'hFF, 8'hFF, 1'b1);
        default: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
      endcase
      sink_mode = sink_mode_e'((phase_no + 1) % 4);
      if (phase_no == 1) hold_req = 1'b1;
      for (int t = 0; t < TxnsPerPhase; t++) begin
        steady = (phase_no == 1 && t < 12);
        send_random_txn();
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
      steady = 1'b0;
    end

    wait_drained();
    $display("Run covered %0d accepted probes, %0d reply bytes and %0d poll reports",
             items_sent, sb.beats_checked, sb.reports_predicted);
    $display("over %0d register settings, four receiver patterns and %0d long hold-offs.",
             settings_used, holds_done);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
